// File: src/button_autorepeat_accelerating_defines.svh
// ----------------------------------------------------------------------------
// button_autorepeat_accelerating_defines.svh
// Assertion macros used by the button auto-repeat RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_AUTOREPEAT_ACCELERATING_DEFINES_SVH
`define BUTTON_AUTOREPEAT_ACCELERATING_DEFINES_SVH

// Condition must never hold outside reset.
`define BAP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BAP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bap_pkg.sv
// ----------------------------------------------------------------------------
// bap_pkg
// Types and constants for the accelerating button auto-repeat block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bap_pkg;

    // Item kinds
    localparam logic KIND_PIN  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Pin bit positions (active low)
    localparam int PIN_UP   = 0;
    localparam int PIN_DOWN = 1;
    localparam int PIN_SEEK = 2;

    localparam int PIN_W  = 3;
    localparam int CFG_W  = 8;
    localparam int CIDX_W = 2;

    localparam logic [PIN_W-1:0] PINS_RELEASED = 3'b111;

    // Register reset values
    localparam logic [CFG_W-1:0] INITIAL_DELAY_RST = 8'd20;
    localparam logic [CFG_W-1:0] SLOW_PERIOD_RST   = 8'd6;
    localparam logic [CFG_W-1:0] SLOW_REPEATS_RST  = 8'd6;
    localparam logic [CFG_W-1:0] FAST_PERIOD_RST   = 8'd2;

    // Register indexes
    typedef enum logic [CIDX_W-1:0] {
        REG_INITIAL_DELAY = 2'd0,
        REG_SLOW_PERIOD   = 2'd1,
        REG_SLOW_REPEATS  = 2'd2,
        REG_FAST_PERIOD   = 2'd3
    } reg_idx_t;

    // Hold stage codes
    typedef enum logic [1:0] {
        STAGE_INIT = 2'd0,
        STAGE_SLOW = 2'd1,
        STAGE_FAST = 2'd2
    } stage_t;

    // One result item
    typedef struct packed {
        logic       repeat_fire;
        logic       repeat_down;
        logic [1:0] hold_stage;
        logic       seek_pulse;
        logic       led;
    } result_t;

endpackage

`default_nettype wire

// File: src/bap_ifs.sv
// ----------------------------------------------------------------------------
// bap_ifs
// Valid/ready channels for button items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bap_in_if;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [bap_pkg::PIN_W-1:0] pins;

    modport source (output valid, output kind, output pins, input ready);
    modport sink   (input valid, input kind, input pins, output ready);
endinterface

interface bap_out_if;
    logic       valid;
    logic       ready;
    logic       repeat_fire;
    logic       repeat_down;
    logic [1:0] hold_stage;
    logic       seek_pulse;
    logic       led;

    modport source (output valid, output repeat_fire, output repeat_down,
                    output hold_stage, output seek_pulse, output led, input ready);
    modport sink   (input valid, input repeat_fire, input repeat_down,
                    input hold_stage, input seek_pulse, input led, output ready);
endinterface

`default_nettype wire

// File: src/button_autorepeat_accelerating.sv
// ----------------------------------------------------------------------------
// button_autorepeat_accelerating
// Edge detection, up/down lockout and three-stage accelerating auto-repeat.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries pin samples (kind 0, active-low pins: up, down, seek) and
//   timer ticks (kind 1). Each accepted item yields exactly one result on
//   out_ch: repeat fire, held direction, hold stage, seek pulse, LED level.
//   Configuration (initial delay, slow period, slow repeat count, fast
//   period) is written through cfg_we/cfg_index/cfg_data while idle.
//   An accepted item waits in the input register; its result is registered
//   when the item moves on, and out_ch.valid rises once it is registered.
//   Throughput: one item per cycle while out_ch takes results; an input
//   register and a result register form a two-entry pipeline, and the state
//   update is one short pass of compare/increment logic between them.
//   When out_ch stalls, the input register still takes one more item; after
//   that in_ch.ready drops until the result is taken.
//   Reset: all buttons released, nothing held, stage initial, counters and
//   LED zero, registers at their default values, both stages empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "button_autorepeat_accelerating_defines.svh"

module button_autorepeat_accelerating (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [bap_pkg::CIDX_W-1:0]  cfg_index,
    input  wire logic [bap_pkg::CFG_W-1:0]   cfg_data,
    bap_in_if.sink                           in_ch,
    bap_out_if.source                        out_ch
);

    // Configuration registers
    logic [bap_pkg::CFG_W-1:0] initial_delay_reg;
    logic [bap_pkg::CFG_W-1:0] slow_period_reg;
    logic [bap_pkg::CFG_W-1:0] slow_repeats_reg;
    logic [bap_pkg::CFG_W-1:0] fast_period_reg;

    // Input stage
    logic                      s1_valid_reg;
    logic                      s1_kind_reg;
    logic [bap_pkg::PIN_W-1:0] s1_pins_reg;
    logic                      s1_move;

    // Block state
    logic [bap_pkg::PIN_W-1:0] last_pins_reg, last_pins_next;
    logic                      up_held_reg, up_held_next;
    logic                      down_held_reg, down_held_next;
    bap_pkg::stage_t           stage_reg, stage_next;
    logic [7:0]                tick_count_reg, tick_count_next;
    logic [7:0]                repeat_count_reg, repeat_count_next;
    logic                      led_reg, led_next;

    // Result stage
    logic                      out_valid_reg;
    bap_pkg::result_t          res_reg, res_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_delay_reg <= bap_pkg::INITIAL_DELAY_RST;
            slow_period_reg   <= bap_pkg::SLOW_PERIOD_RST;
            slow_repeats_reg  <= bap_pkg::SLOW_REPEATS_RST;
            fast_period_reg   <= bap_pkg::FAST_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (bap_pkg::reg_idx_t'(cfg_index))
                bap_pkg::REG_INITIAL_DELAY: initial_delay_reg <= cfg_data;
                bap_pkg::REG_SLOW_PERIOD:   slow_period_reg   <= cfg_data;
                bap_pkg::REG_SLOW_REPEATS:  slow_repeats_reg  <= cfg_data;
                bap_pkg::REG_FAST_PERIOD:   fast_period_reg   <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Handshake: input stage drains whenever the result register frees
    assign s1_move      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || s1_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_kind_reg <= in_ch.kind;
            s1_pins_reg <= in_ch.pins;
        end
    end

    // Next state and result for the item in the input stage
    always_comb
    begin
        logic [bap_pkg::PIN_W-1:0] fell;
        logic [bap_pkg::PIN_W-1:0] rose;
        logic [7:0]                limit;
        logic                      bad_stage;
        logic                      fire;
        logic                      seek;

        fell              = last_pins_reg & ~s1_pins_reg;
        rose              = ~last_pins_reg & s1_pins_reg;
        limit             = initial_delay_reg;
        bad_stage         = 1'b0;
        fire              = 1'b0;
        seek              = 1'b0;
        last_pins_next    = last_pins_reg;
        up_held_next      = up_held_reg;
        down_held_next    = down_held_reg;
        stage_next        = stage_reg;
        tick_count_next   = tick_count_reg;
        repeat_count_next = repeat_count_reg;
        led_next          = led_reg;

        if (s1_kind_reg == bap_pkg::KIND_PIN)
        begin
            // Up: toggle LED on press, hold unless down is held
            if (fell[bap_pkg::PIN_UP])
            begin
                led_next = ~led_next;
                if (!down_held_next)
                begin
                    up_held_next = 1'b1;
                end
            end
            if (rose[bap_pkg::PIN_UP])
            begin
                up_held_next      = 1'b0;
                stage_next        = bap_pkg::STAGE_INIT;
                tick_count_next   = '0;
                repeat_count_next = '0;
            end
            // Down: set LED on press, hold unless up is held
            if (fell[bap_pkg::PIN_DOWN])
            begin
                led_next = 1'b1;
                if (!up_held_next)
                begin
                    down_held_next = 1'b1;
                end
            end
            if (rose[bap_pkg::PIN_DOWN])
            begin
                down_held_next    = 1'b0;
                stage_next        = bap_pkg::STAGE_INIT;
                tick_count_next   = '0;
                repeat_count_next = '0;
            end
            // Seek: clear LED and pulse
            if (fell[bap_pkg::PIN_SEEK])
            begin
                led_next = 1'b0;
                seek     = 1'b1;
            end
            last_pins_next = s1_pins_reg;
        end
        else if (up_held_reg || down_held_reg)
        begin
            // Stage threshold select
            case (stage_reg)
                bap_pkg::STAGE_INIT: limit = initial_delay_reg;
                bap_pkg::STAGE_SLOW: limit = slow_period_reg;
                bap_pkg::STAGE_FAST: limit = fast_period_reg;
                default:             bad_stage = 1'b1;
            endcase

            if (bad_stage)
            begin
                stage_next        = bap_pkg::STAGE_INIT;
                tick_count_next   = '0;
                repeat_count_next = '0;
            end
            else if (tick_count_reg > limit)
            begin
                fire            = 1'b1;
                tick_count_next = '0;
                led_next        = ~led_reg;
                if (stage_reg == bap_pkg::STAGE_INIT)
                begin
                    stage_next = bap_pkg::STAGE_SLOW;
                end
                else if (stage_reg == bap_pkg::STAGE_SLOW)
                begin
                    if (repeat_count_reg > slow_repeats_reg)
                    begin
                        stage_next        = bap_pkg::STAGE_FAST;
                        repeat_count_next = '0;
                    end
                    else
                    begin
                        repeat_count_next = repeat_count_reg + 8'd1;
                    end
                end
            end
            else
            begin
                tick_count_next = tick_count_reg + 8'd1;
            end
        end

        res_next.repeat_fire = fire;
        res_next.repeat_down = down_held_next;
        res_next.hold_stage  = stage_next;
        res_next.seek_pulse  = seek;
        res_next.led         = led_next;
    end

    // State commits when the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pins_reg    <= bap_pkg::PINS_RELEASED;
            up_held_reg      <= 1'b0;
            down_held_reg    <= 1'b0;
            stage_reg        <= bap_pkg::STAGE_INIT;
            tick_count_reg   <= '0;
            repeat_count_reg <= '0;
            led_reg          <= 1'b0;
        end
        else if (s1_move)
        begin
            last_pins_reg    <= last_pins_next;
            up_held_reg      <= up_held_next;
            down_held_reg    <= down_held_next;
            stage_reg        <= stage_next;
            tick_count_reg   <= tick_count_next;
            repeat_count_reg <= repeat_count_next;
            led_reg          <= led_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.repeat_fire = res_reg.repeat_fire;
    assign out_ch.repeat_down = res_reg.repeat_down;
    assign out_ch.hold_stage  = res_reg.hold_stage;
    assign out_ch.seek_pulse  = res_reg.seek_pulse;
    assign out_ch.led         = res_reg.led;

    // Checks
    `BAP_ASSERT_NEVER(a_lockout, clk, rst_n, up_held_reg && down_held_reg, "up and down both held")
    `BAP_ASSERT_NEVER(a_stage_code, clk, rst_n, stage_reg == 2'd3, "hold stage code three")
    `BAP_ASSERT_NEXT(a_pin_no_fire, clk, rst_n, s1_move && (s1_kind_reg == bap_pkg::KIND_PIN), !res_reg.repeat_fire, "repeat fired on a pin sample")
    `BAP_ASSERT_IMPL(a_seek_led, clk, rst_n, out_valid_reg && res_reg.seek_pulse, !res_reg.led, "LED lit on seek press")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the accelerating button auto-repeat block.
// A queue of pin samples and timer ticks feeds a valid/ready driver. An
// in-bench model of press/release edges, up/down lockout and the three-stage
// repeat predicts one result per transfer. The monitor compares each result
// with the oldest prediction. Configuration changes only between phases,
// once the block has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_PCT    = 18;
    localparam int STALL_LIMIT = 1000;
    localparam int SPAN_CAP    = 300;

    typedef struct packed {
        logic                      kind;
        logic [bap_pkg::PIN_W-1:0] pins;
    } button_item_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [bap_pkg::CIDX_W-1:0] cfg_index;
    logic [bap_pkg::CFG_W-1:0]  cfg_data;

    bap_in_if  in_ch ();
    bap_out_if out_ch ();

    button_autorepeat_accelerating dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Items waiting to be driven, results waiting to arrive
    button_item_t              press_stream[$];
    bap_pkg::result_t          button_results_due[$];
    int                        n_queued = 0;
    int                        n_done = 0;
    int                        errors = 0;
    int                        stall_cycles = 0;
    logic                      steady = 1'b0;
    logic [bap_pkg::PIN_W-1:0] gen_pins = bap_pkg::PINS_RELEASED;

    // Register copies
    logic [bap_pkg::CFG_W-1:0] delay_first = bap_pkg::INITIAL_DELAY_RST;
    logic [bap_pkg::CFG_W-1:0] period_slow = bap_pkg::SLOW_PERIOD_RST;
    logic [bap_pkg::CFG_W-1:0] count_slow  = bap_pkg::SLOW_REPEATS_RST;
    logic [bap_pkg::CFG_W-1:0] period_fast = bap_pkg::FAST_PERIOD_RST;

    // Button and repeat state
    logic [bap_pkg::PIN_W-1:0] prev_pins = bap_pkg::PINS_RELEASED;
    logic                      up_on = 1'b0;
    logic                      down_on = 1'b0;
    logic [1:0]                hold_stg = bap_pkg::STAGE_INIT;
    logic [7:0]                tick_cnt = 8'd0;
    logic [7:0]                rep_cnt = 8'd0;
    logic                      led_q = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void clear_hold();
        hold_stg = bap_pkg::STAGE_INIT;
        tick_cnt = 8'd0;
        rep_cnt  = 8'd0;
    endfunction

    // Advance the button state by one item and return the result it yields
    function automatic bap_pkg::result_t step_buttons(logic kind,
                                                      logic [bap_pkg::PIN_W-1:0] pins);
        bap_pkg::result_t r;
        logic [7:0]       limit;
        logic             known;
        r = '0;
        known = 1'b1;
        limit = 8'd0;
        if (kind == bap_pkg::KIND_PIN)
        begin
            if (!pins[bap_pkg::PIN_UP] && prev_pins[bap_pkg::PIN_UP])
            begin
                led_q = ~led_q;
                if (!down_on)
                    up_on = 1'b1;
            end
            if (pins[bap_pkg::PIN_UP] && !prev_pins[bap_pkg::PIN_UP])
            begin
                up_on = 1'b0;
                clear_hold();
            end
            if (!pins[bap_pkg::PIN_DOWN] && prev_pins[bap_pkg::PIN_DOWN])
            begin
                led_q = 1'b1;
                if (!up_on)
                    down_on = 1'b1;
            end
            if (pins[bap_pkg::PIN_DOWN] && !prev_pins[bap_pkg::PIN_DOWN])
            begin
                down_on = 1'b0;
                clear_hold();
            end
            if (!pins[bap_pkg::PIN_SEEK] && prev_pins[bap_pkg::PIN_SEEK])
            begin
                led_q = 1'b0;
                r.seek_pulse = 1'b1;
            end
            prev_pins = pins;
        end
        else if (up_on || down_on)
        begin
            case (hold_stg)
                bap_pkg::STAGE_INIT: limit = delay_first;
                bap_pkg::STAGE_SLOW: limit = period_slow;
                bap_pkg::STAGE_FAST: limit = period_fast;
                default:
                begin
                    clear_hold();
                    known = 1'b0;
                end
            endcase
            if (known && tick_cnt > limit)
            begin
                tick_cnt = 8'd0;
                led_q = ~led_q;
                r.repeat_fire = 1'b1;
                if (hold_stg == bap_pkg::STAGE_INIT)
                    hold_stg = bap_pkg::STAGE_SLOW;
                else if (hold_stg == bap_pkg::STAGE_SLOW)
                begin
                    if (rep_cnt > count_slow)
                    begin
                        hold_stg = bap_pkg::STAGE_FAST;
                        rep_cnt = 8'd0;
                    end
                    else
                        rep_cnt = rep_cnt + 8'd1;
                end
            end
            else if (known)
                tick_cnt = tick_cnt + 8'd1;
        end
        r.repeat_down = down_on;
        r.hold_stage  = hold_stg;
        r.led         = led_q;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [1:0] want,
                               input logic [1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Driver: next item offered once the current one has transferred
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        button_item_t next_item;
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (press_stream.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                next_item = press_stream.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.kind  <= next_item.kind;
                in_ch.pins  <= next_item.pins;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Result sink stalls at random unless steady is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: check results, predict on input transfers, watchdog
    always @(posedge clk)
    begin : watch_results
        bap_pkg::result_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (button_results_due.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    errors++;
                end
                else
                begin
                    want = button_results_due.pop_front();
                    check_field("repeat_fire", 2'(want.repeat_fire),
                                2'(out_ch.repeat_fire));
                    check_field("repeat_down", 2'(want.repeat_down),
                                2'(out_ch.repeat_down));
                    check_field("hold_stage", want.hold_stage, out_ch.hold_stage);
                    check_field("seek_pulse", 2'(want.seek_pulse),
                                2'(out_ch.seek_pulse));
                    check_field("led", 2'(want.led), 2'(out_ch.led));
                end
                n_done++;
            end
            if (in_ch.valid && in_ch.ready)
                button_results_due.push_back(step_buttons(in_ch.kind, in_ch.pins));
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    task automatic add_item(input logic kind, input logic [bap_pkg::PIN_W-1:0] pins);
        button_item_t it;
        it.kind = kind;
        it.pins = pins;
        press_stream.push_back(it);
        n_queued++;
        if (kind == bap_pkg::KIND_PIN)
            gen_pins = pins;
    endtask

    task automatic wait_drained();
        while (n_done != n_queued)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write all four registers on consecutive edges; block is idle here
    task automatic set_config(input logic [bap_pkg::CFG_W-1:0] d0,
                              input logic [bap_pkg::CFG_W-1:0] d1,
                              input logic [bap_pkg::CFG_W-1:0] d2,
                              input logic [bap_pkg::CFG_W-1:0] d3);
        delay_first = d0;
        period_slow = d1;
        count_slow  = d2;
        period_fast = d3;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= bap_pkg::REG_INITIAL_DELAY;
        cfg_data  <= d0;
        @(posedge clk);
        cfg_index <= bap_pkg::REG_SLOW_PERIOD;
        cfg_data  <= d1;
        @(posedge clk);
        cfg_index <= bap_pkg::REG_SLOW_REPEATS;
        cfg_data  <= d2;
        @(posedge clk);
        cfg_index <= bap_pkg::REG_FAST_PERIOD;
        cfg_data  <= d3;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One hold of up or down: press, ticks with scattered pin activity, release
    // (at most span + 3 items)
    task automatic hold_burst(input int span);
        int n;
        int pick;
        int held_bit;
        int other_bit;
        logic [bap_pkg::PIN_W-1:0] p;
        if (gen_pins[1:0] != 2'b11)
            add_item(bap_pkg::KIND_PIN, gen_pins | 3'b011);
        held_bit  = $urandom_range(1) ? bap_pkg::PIN_DOWN : bap_pkg::PIN_UP;
        other_bit = (held_bit == bap_pkg::PIN_UP) ? bap_pkg::PIN_DOWN : bap_pkg::PIN_UP;
        p = gen_pins;
        p[held_bit] = 1'b0;
        add_item(bap_pkg::KIND_PIN, p);
        n = ($urandom_range(2) == 0) ? span : $urandom_range(span);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            p = gen_pins;
            if (pick < 4)
            begin
                // locked-out button goes down or up
                p[other_bit] = ~p[other_bit];
                add_item(bap_pkg::KIND_PIN, p);
            end
            else if (pick < 8)
            begin
                p[bap_pkg::PIN_SEEK] = ~p[bap_pkg::PIN_SEEK];
                add_item(bap_pkg::KIND_PIN, p);
            end
            else
                add_item(bap_pkg::KIND_TICK, bap_pkg::PIN_W'($urandom_range(7)));
        end
        p = gen_pins;
        if ($urandom_range(1))
            p = p | 3'b011;
        else
            p[held_bit] = 1'b1;
        add_item(bap_pkg::KIND_PIN, p);
    endtask

    // Random traffic; the last burst is trimmed so the phase stays on budget
    task automatic run_phase(input int budget);
        int start;
        int span;
        int room;
        start = n_queued;
        span = delay_first + 2 + (period_slow + 2) * (count_slow + 2) + 3 * (period_fast + 2);
        if (span > SPAN_CAP)
            span = SPAN_CAP;
        while (n_queued - start < budget)
        begin
            room = budget - (n_queued - start);
            if (room < 4 || $urandom_range(99) < 15)
                add_item(1'($urandom_range(1)), bap_pkg::PIN_W'($urandom_range(7)));
            else if (span > room - 4)
                hold_burst(room - 4);
            else
                hold_burst(span);
        end
    endtask

    // Stimulus
    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = bap_pkg::REG_INITIAL_DELAY;
        cfg_data    = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: all thresholds zero so every stage is reached quickly
        set_config(8'd0, 8'd0, 8'd0, 8'd0);
        add_item(bap_pkg::KIND_PIN, 3'b111);
        add_item(bap_pkg::KIND_PIN, 3'b011);         // seek press
        add_item(bap_pkg::KIND_PIN, 3'b111);
        add_item(bap_pkg::KIND_TICK, 3'b000);        // nothing held, ignored
        add_item(bap_pkg::KIND_PIN, 3'b110);         // up press
        add_item(bap_pkg::KIND_PIN, 3'b100);         // down locked out
        for (int i = 0; i < 8; i++)
            add_item(bap_pkg::KIND_TICK, i[0] ? 3'b111 : 3'b000);
        add_item(bap_pkg::KIND_PIN, 3'b101);         // up release while down is down
        add_item(bap_pkg::KIND_TICK, 3'b010);
        add_item(bap_pkg::KIND_PIN, 3'b111);         // release of locked-out down
        add_item(bap_pkg::KIND_PIN, 3'b101);         // down press
        add_item(bap_pkg::KIND_PIN, 3'b100);         // up locked out
        add_item(bap_pkg::KIND_TICK, 3'b111);
        add_item(bap_pkg::KIND_TICK, 3'b000);
        add_item(bap_pkg::KIND_PIN, 3'b000);         // seek press while both down
        add_item(bap_pkg::KIND_PIN, 3'b111);
        wait_drained();

        set_config(bap_pkg::INITIAL_DELAY_RST, bap_pkg::SLOW_PERIOD_RST,
                   bap_pkg::SLOW_REPEATS_RST, bap_pkg::FAST_PERIOD_RST);
        run_phase(250);
        wait_drained();

        // Thresholds at maximum: the tick counter wraps, nothing fires
        set_config(8'd255, 8'd255, 8'd255, 8'd255);
        run_phase(330);
        wait_drained();

        steady = 1'b1;
        set_config(8'd3, 8'd1, 8'd2, 8'd0);
        run_phase(200);
        wait_drained();
        steady = 1'b0;

        set_config(8'd1, 8'd0, 8'd255, 8'd1);
        run_phase(200);
        wait_drained();

        set_config(bap_pkg::CFG_W'($urandom_range(8)), bap_pkg::CFG_W'($urandom_range(8)),
                   bap_pkg::CFG_W'($urandom_range(8)), bap_pkg::CFG_W'($urandom_range(8)));
        run_phase(125);
        wait_drained();
        run_phase(125);
        wait_drained();

        set_config(8'd7, 8'd2, 8'd0, 8'd255);
        run_phase(200);
        wait_drained();

        if (button_results_due.size() != 0)
        begin
            $error("%0d results never arrived", button_results_due.size());
            errors++;
        end
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/bap_pkg.sv
src/bap_ifs.sv
src/button_autorepeat_accelerating.sv
tb/sv/tb.sv
